// ===== rtl/cpt_pkg.sv =====
package cpt_pkg;

  localparam int MUL_DIGIT = 16;

  typedef logic [2:0] region_t;

  localparam region_t REG_VA    = 3'd0;
  localparam region_t REG_VB    = 3'd1;
  localparam region_t REG_VC    = 3'd2;
  localparam region_t REG_AB    = 3'd3;
  localparam region_t REG_BC    = 3'd4;
  localparam region_t REG_CA    = 3'd5;
  localparam region_t REG_FACE  = 3'd6;
  localparam region_t REG_DEGEN = 3'd7;

endpackage

// ===== rtl/cpt_mul.sv =====
module cpt_mul import cpt_pkg::*; #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                     clk,
  input  logic signed [WA-1:0]     a,
  input  logic signed [WB-1:0]     b,
  output logic signed [WA+WB-1:0]  p
);

  localparam int ND = (WB + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BX = ND * MUL_DIGIT;
  localparam int PW = WA + WB;

  logic signed [WA-1:0] a_r [ND];
  logic [BX-1:0]        b_r [ND];
  logic signed [PW-1:0] acc [ND];
  logic [BX-1:0]        bx;

  assign bx = BX'(b);

  for (genvar k = 0; k < ND; k++) begin : g_st
    logic signed [WA-1:0]          a_in;
    logic [BX-1:0]                 b_in;
    logic signed [PW-1:0]          acc_in;
    logic signed [MUL_DIGIT:0]     dig;
    logic signed [WA+MUL_DIGIT:0]  pp;

    if (k == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = bx;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc[k-1];
    end

    if (k == ND - 1) begin : g_top
      assign dig = {b_in[k*MUL_DIGIT+MUL_DIGIT-1], b_in[k*MUL_DIGIT +: MUL_DIGIT]};
    end else begin : g_low
      assign dig = {1'b0, b_in[k*MUL_DIGIT +: MUL_DIGIT]};
    end

    assign pp = a_in * dig;

    always_ff @(posedge clk) begin
      acc[k] <= acc_in + (PW'(pp) << (k * MUL_DIGIT));
      a_r[k] <= a_in;
      b_r[k] <= b_in;
    end
  end

  assign p = acc[ND-1];

endmodule

// ===== rtl/cpt_div.sv =====
module cpt_div import cpt_pkg::*; #(
  parameter int NUMW = 170,
  parameter int DENW = 136,
  parameter int QW   = 32
) (
  input  logic                   clk,
  input  logic signed [NUMW-1:0] num,
  input  logic [DENW-1:0]        den,
  output logic signed [QW-1:0]   q
);

  logic [NUMW-1:0] rem_s [QW+1];
  logic [QW-1:0]   qt_s  [QW+1];
  logic [DENW-1:0] den_s [QW+1];
  logic            neg_s [QW+1];
  logic [DENW:0]   rem2;
  logic            rnd;
  logic [QW:0]     qq;

  always_ff @(posedge clk) begin
    neg_s[0] <= num[NUMW-1];
    rem_s[0] <= num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    den_s[0] <= den;
    qt_s[0]  <= '0;
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [NUMW-1:0] sden;
    logic            ge;

    assign sden = NUMW'(den_s[i-1]) << (QW - i);
    assign ge   = rem_s[i-1] >= sden;

    always_ff @(posedge clk) begin
      rem_s[i] <= ge ? rem_s[i-1] - sden : rem_s[i-1];
      qt_s[i]  <= {qt_s[i-1][QW-2:0], ge};
      den_s[i] <= den_s[i-1];
      neg_s[i] <= neg_s[i-1];
    end
  end

  assign rem2 = {rem_s[QW][DENW-1:0], 1'b0};
  assign rnd  = rem2 >= (DENW+1)'(den_s[QW]);
  assign qq   = (QW+1)'(qt_s[QW]) + (QW+1)'(rnd);

  always_ff @(posedge clk) begin
    q <= neg_s[QW] ? QW'(-qq) : QW'(qq);
  end

endmodule

// ===== rtl/cpt_dly.sv =====
module cpt_dly import cpt_pkg::*; #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int i = 1; i < N; i++) begin
      sr[i] <= sr[i-1];
    end
  end

  assign q = sr[N-1];

endmodule

// ===== rtl/closest_point_on_triangle_top.sv =====
// Channel   Direction  Signals                                   Handshake
// request   in         ax..az, bx..bz, cx..cz, qx..qz            start high, busy low
// result    out        near_x, near_y, near_z, region, valid_res done for one cycle
//
// A new request is taken every cycle while busy is low.
// L1, L2 and L3 are the digit stages of the three chained multiplier banks, and the
// restoring divider retires one quotient bit per stage.
// Synchronous reset clears the valid pipeline; busy is high during reset and until the
// first clock edge that samples rst low.
// Results cannot be held off, so nothing in the pipeline ever waits.
module closest_point_on_triangle_top import cpt_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] cz,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic signed [COORD_BITS-1:0] qz,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] near_x,
  output logic signed [COORD_BITS-1:0] near_y,
  output logic signed [COORD_BITS-1:0] near_z,
  output region_t                      region,
  output logic                         valid_res
);

  localparam int CB  = COORD_BITS;
  localparam int D   = CB + 1;
  localparam int NW  = 2 * CB + 3;
  localparam int EW  = 2 * CB + 4;
  localparam int FW  = 4 * CB + 8;
  localparam int SW  = FW + CB + 2;
  localparam int QW  = CB;
  localparam int L1  = (D + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int L2  = (NW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int L3  = (FW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int LAT = 7 + L1 + L2 + L3 + QW;

  function automatic logic nonpos_e(input logic signed [EW-1:0] x);
    return x[EW-1] || (x == '0);
  endfunction

  function automatic logic nonpos_f(input logic signed [FW-1:0] x);
    return x[FW-1] || (x == '0);
  endfunction

  logic           accept;
  logic [LAT-1:0] vld;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      vld  <= '0;
    end else begin
      busy <= 1'b0;
      vld  <= {vld[LAT-2:0], accept};
    end
  end

  assign done = vld[LAT-1];

  logic signed [CB-1:0] pa [3];
  logic signed [CB-1:0] pb [3];
  logic signed [CB-1:0] pc [3];
  logic signed [CB-1:0] pq [3];

  assign pa[0] = ax;
  assign pa[1] = ay;
  assign pa[2] = az;
  assign pb[0] = bx;
  assign pb[1] = by;
  assign pb[2] = bz;
  assign pc[0] = cx;
  assign pc[1] = cy;
  assign pc[2] = cz;
  assign pq[0] = qx;
  assign pq[1] = qy;
  assign pq[2] = qz;

  logic signed [D-1:0] da [3], db [3], dc [3];
  logic signed [D-1:0] qa [3], qb [3], qc [3];
  logic signed [D-1:0] eab [3], ebc [3], eca [3], eac [3];
  logic [9*CB-1:0]     vtx_r;
  logic [9*CB-1:0]     vtx_d;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      da[k]  <= D'(pa[k]) - D'(pq[k]);
      db[k]  <= D'(pb[k]) - D'(pq[k]);
      dc[k]  <= D'(pc[k]) - D'(pq[k]);
      qa[k]  <= D'(pq[k]) - D'(pa[k]);
      qb[k]  <= D'(pq[k]) - D'(pb[k]);
      qc[k]  <= D'(pq[k]) - D'(pc[k]);
      eab[k] <= D'(pb[k]) - D'(pa[k]);
      ebc[k] <= D'(pc[k]) - D'(pb[k]);
      eca[k] <= D'(pa[k]) - D'(pc[k]);
      eac[k] <= D'(pc[k]) - D'(pa[k]);
      vtx_r[k*CB +: CB]       <= pa[k];
      vtx_r[(3+k)*CB +: CB]   <= pb[k];
      vtx_r[(6+k)*CB +: CB]   <= pc[k];
    end
  end

  cpt_dly #(.W(9*CB), .N(3 + L1 + L2)) u_vtx_dly (
    .clk (clk),
    .d   (vtx_r),
    .q   (vtx_d)
  );

  // Edge dot products: u and v for edges AB, BC and CA.
  logic signed [D-1:0]  dx [6][3];
  logic signed [D-1:0]  dy [6][3];
  logic signed [EW-1:0] edg [6];
  logic [6*EW-1:0]      edg_flat;
  logic [6*EW-1:0]      edg_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[0][k] = db[k];
      dy[0][k] = eab[k];
      dx[1][k] = qa[k];
      dy[1][k] = eab[k];
      dx[2][k] = dc[k];
      dy[2][k] = ebc[k];
      dx[3][k] = qb[k];
      dy[3][k] = ebc[k];
      dx[4][k] = da[k];
      dy[4][k] = eca[k];
      dx[5][k] = qc[k];
      dy[5][k] = eca[k];
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_edot
    logic signed [2*D-1:0] pr [3];
    for (genvar k = 0; k < 3; k++) begin : g_c
      cpt_mul #(.WA(D), .WB(D)) u_mul (
        .clk (clk),
        .a   (dx[j][k]),
        .b   (dy[j][k]),
        .p   (pr[k])
      );
    end
    always_ff @(posedge clk) begin
      edg[j] <= EW'(pr[0]) + EW'(pr[1]) + EW'(pr[2]);
    end
    assign edg_flat[j*EW +: EW] = edg[j];
  end

  cpt_dly #(.W(6*EW), .N(L2 + 1)) u_edg_dly (
    .clk (clk),
    .d   (edg_flat),
    .q   (edg_d)
  );

  // Cross products: the normal and the three sub-triangle normals.
  logic signed [D-1:0]  cxa [4][3];
  logic signed [D-1:0]  cya [4][3];
  logic signed [NW-1:0] crs [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cxa[0][k] = eab[k];
      cya[0][k] = eac[k];
      cxa[1][k] = db[k];
      cya[1][k] = dc[k];
      cxa[2][k] = dc[k];
      cya[2][k] = da[k];
      cxa[3][k] = da[k];
      cya[3][k] = db[k];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_cross
    for (genvar k = 0; k < 3; k++) begin : g_c
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;
      logic signed [2*D-1:0] m1, m2;
      cpt_mul #(.WA(D), .WB(D)) u_m1 (
        .clk (clk),
        .a   (cxa[j][K1]),
        .b   (cya[j][K2]),
        .p   (m1)
      );
      cpt_mul #(.WA(D), .WB(D)) u_m2 (
        .clk (clk),
        .a   (cxa[j][K2]),
        .b   (cya[j][K1]),
        .p   (m2)
      );
      always_ff @(posedge clk) begin
        crs[j][k] <= NW'(m1) - NW'(m2);
      end
    end
  end

  // Face weights for A, B, C and the face divisor.
  logic signed [FW-1:0] fw [4];

  for (genvar j = 0; j < 4; j++) begin : g_fdot
    localparam int JA = (j == 3) ? 0 : j + 1;
    logic signed [2*NW-1:0] pr [3];
    for (genvar k = 0; k < 3; k++) begin : g_c
      cpt_mul #(.WA(NW), .WB(NW)) u_mul (
        .clk (clk),
        .a   (crs[JA][k]),
        .b   (crs[0][k]),
        .p   (pr[k])
      );
    end
    always_ff @(posedge clk) begin
      fw[j] <= FW'(pr[0]) + FW'(pr[1]) + FW'(pr[2]);
    end
  end

  logic signed [EW-1:0] ed [6];

  for (genvar j = 0; j < 6; j++) begin : g_edu
    assign ed[j] = edg_d[j*EW +: EW];
  end

  logic signed [FW-1:0] wgt_next [3];
  logic signed [FW-1:0] wgt [3];
  logic [FW-1:0]        den_next, den;
  region_t              rgn_next, rgn;
  logic                 flat;

  always_comb begin
    flat     = (fw[3] == '0);
    wgt_next = '{default: '0};
    den_next = FW'(1);
    rgn_next = REG_FACE;
    if (nonpos_e(ed[1]) && nonpos_e(ed[4])) begin
      rgn_next    = REG_VA;
      wgt_next[0] = FW'(1);
    end else if (nonpos_e(ed[0]) && nonpos_e(ed[3])) begin
      rgn_next    = REG_VB;
      wgt_next[1] = FW'(1);
    end else if (nonpos_e(ed[2]) && nonpos_e(ed[5])) begin
      rgn_next    = REG_VC;
      wgt_next[2] = FW'(1);
    end else if (!nonpos_e(ed[0]) && !nonpos_e(ed[1]) && (flat || nonpos_f(fw[2]))) begin
      rgn_next    = REG_AB;
      wgt_next[0] = FW'(ed[0]);
      wgt_next[1] = FW'(ed[1]);
      den_next    = FW'(ed[0]) + FW'(ed[1]);
    end else if (!nonpos_e(ed[2]) && !nonpos_e(ed[3]) && (flat || nonpos_f(fw[0]))) begin
      rgn_next    = REG_BC;
      wgt_next[1] = FW'(ed[2]);
      wgt_next[2] = FW'(ed[3]);
      den_next    = FW'(ed[2]) + FW'(ed[3]);
    end else if (!nonpos_e(ed[4]) && !nonpos_e(ed[5]) && (flat || nonpos_f(fw[1]))) begin
      rgn_next    = REG_CA;
      wgt_next[2] = FW'(ed[4]);
      wgt_next[0] = FW'(ed[5]);
      den_next    = FW'(ed[4]) + FW'(ed[5]);
    end else if (flat) begin
      rgn_next    = REG_DEGEN;
    end else begin
      wgt_next[0] = fw[0];
      wgt_next[1] = fw[1];
      wgt_next[2] = fw[2];
      den_next    = fw[3];
    end
  end

  always_ff @(posedge clk) begin
    wgt    <= wgt_next;
    den    <= den_next;
    rgn    <= rgn_next;
  end

  logic [FW-1:0] den_d;

  cpt_dly #(.W(FW), .N(L3 + 1)) u_den_dly (
    .clk (clk),
    .d   (den),
    .q   (den_d)
  );

  cpt_dly #(.W(3), .N(L3 + 3 + QW)) u_rgn_dly (
    .clk (clk),
    .d   (rgn),
    .q   (region)
  );

  assign valid_res = (region != REG_DEGEN);

  logic signed [CB-1:0] near [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [CB+FW-1:0] pr [3];
    logic signed [SW-1:0]    num;
    for (genvar v = 0; v < 3; v++) begin : g_v
      cpt_mul #(.WA(CB), .WB(FW)) u_mul (
        .clk (clk),
        .a   (vtx_d[(3*v+k)*CB +: CB]),
        .b   (wgt[v]),
        .p   (pr[v])
      );
    end
    always_ff @(posedge clk) begin
      num <= SW'(pr[0]) + SW'(pr[1]) + SW'(pr[2]);
    end
    cpt_div #(.NUMW(SW), .DENW(FW), .QW(QW)) u_div (
      .clk (clk),
      .num (num),
      .den (den_d),
      .q   (near[k])
    );
  end

  assign near_x = near[0];
  assign near_y = near[1];
  assign near_z = near[2];

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && (region == REG_DEGEN) |-> (near_x == '0) && (near_y == '0) && (near_z == '0))
    else $error("degenerate result carries a nonzero point");

  a_vertex_a: assert property (@(posedge clk) disable iff (rst)
    done && (region == REG_VA) && $past(accept, LAT) |->
      (near_x == $past(ax, LAT)) && (near_y == $past(ay, LAT)) && (near_z == $past(az, LAT)))
    else $error("vertex A result differs from the requested vertex");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done && busy)
    else $error("result strobe or ready seen right after reset");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result strobe without a matching request");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench import cpt_pkg::*;;

  localparam int CW = 32;
  localparam int WIDE = 320;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic signed [WIDE-1:0] wide_t;

  typedef struct packed {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy, qz;
  } query_t;

  typedef struct packed {
    logic signed [CW-1:0] px, py, pz;
    region_t              reg_code;
    logic                 ok;
  } answer_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy, qz;
  logic done;
  logic signed [CW-1:0] near_x, near_y, near_z;
  region_t region;
  logic valid_res;

  answer_t pending_answers[$];
  int      fail_count;
  int      cycle_count;
  int      request_count;
  int      region_hits[8];
  logic    busy_seen;

  closest_point_on_triangle_top #(.COORD_BITS(CW)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
    .cx(cx), .cy(cy), .cz(cz), .qx(qx), .qy(qy), .qz(qz),
    .done(done), .near_x(near_x), .near_y(near_y), .near_z(near_z),
    .region(region), .valid_res(valid_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic wide_t dot3(wide_t x0, wide_t y0, wide_t z0,
                                 wide_t x1, wide_t y1, wide_t z1);
    return x0 * x1 + y0 * y1 + z0 * z1;
  endfunction

  function automatic logic [CW-1:0] div_nearest(wide_t num, wide_t den);
    logic [WIDE-1:0] mag;
    logic [WIDE-1:0] quo;
    logic [WIDE-1:0] rem;
    logic [WIDE-1:0] uden;
    uden = den;
    mag = (num < 0) ? -num : num;
    quo = mag / uden;
    rem = mag - quo * uden;
    if ((rem << 1) >= uden) quo = quo + 1;
    if (num < 0) quo = -quo;
    return quo[CW-1:0];
  endfunction

  function automatic answer_t closest_point(query_t t);
    wide_t p[3][3];
    wide_t q[3];
    wide_t ew[3][3];
    wide_t e[3];
    wide_t n[3];
    wide_t d0[3];
    wide_t d1[3];
    wide_t d2[3];
    wide_t fw[3];
    wide_t fs;
    wide_t c[3];
    wide_t num;
    answer_t r;
    logic flat;
    int i;
    int j;
    int k;
    p[0][0] = t.ax; p[0][1] = t.ay; p[0][2] = t.az;
    p[1][0] = t.bx; p[1][1] = t.by; p[1][2] = t.bz;
    p[2][0] = t.cx; p[2][1] = t.cy; p[2][2] = t.cz;
    q[0] = t.qx; q[1] = t.qy; q[2] = t.qz;
    // Edge i runs from vertex i to vertex (i+1)%3: AB, BC, CA.
    for (i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      for (k = 0; k < 3; k++) e[k] = p[j][k] - p[i][k];
      ew[i][0] = dot3(p[j][0] - q[0], p[j][1] - q[1], p[j][2] - q[2], e[0], e[1], e[2]);
      ew[i][1] = dot3(q[0] - p[i][0], q[1] - p[i][1], q[2] - p[i][2], e[0], e[1], e[2]);
      ew[i][2] = dot3(e[0], e[1], e[2], e[0], e[1], e[2]);
    end
    r = '0;
    r.ok = 1'b1;
    if (ew[0][1] <= 0 && ew[2][0] <= 0) begin
      r.reg_code = REG_VA; r.px = t.ax; r.py = t.ay; r.pz = t.az;
      return r;
    end
    if (ew[0][0] <= 0 && ew[1][1] <= 0) begin
      r.reg_code = REG_VB; r.px = t.bx; r.py = t.by; r.pz = t.bz;
      return r;
    end
    if (ew[1][0] <= 0 && ew[2][1] <= 0) begin
      r.reg_code = REG_VC; r.px = t.cx; r.py = t.cy; r.pz = t.cz;
      return r;
    end
    for (k = 0; k < 3; k++) begin
      d0[k] = p[0][k] - q[k];
      d1[k] = p[1][k] - q[k];
      d2[k] = p[2][k] - q[k];
      e[k] = p[1][k] - p[0][k];
      c[k] = p[2][k] - p[0][k];
    end
    n[0] = e[1] * c[2] - e[2] * c[1];
    n[1] = e[2] * c[0] - e[0] * c[2];
    n[2] = e[0] * c[1] - e[1] * c[0];
    fw[0] = dot3(d1[1] * d2[2] - d1[2] * d2[1], d1[2] * d2[0] - d1[0] * d2[2],
                 d1[0] * d2[1] - d1[1] * d2[0], n[0], n[1], n[2]);
    fw[1] = dot3(d2[1] * d0[2] - d2[2] * d0[1], d2[2] * d0[0] - d2[0] * d0[2],
                 d2[0] * d0[1] - d2[1] * d0[0], n[0], n[1], n[2]);
    fw[2] = dot3(d0[1] * d1[2] - d0[2] * d1[1], d0[2] * d1[0] - d0[0] * d1[2],
                 d0[0] * d1[1] - d0[1] * d1[0], n[0], n[1], n[2]);
    fs = dot3(n[0], n[1], n[2], n[0], n[1], n[2]);
    flat = (fs == 0);
    // The edge opposite vertex (i+2)%3 is limited by that vertex's face weight.
    for (i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      if (ew[i][0] > 0 && ew[i][1] > 0 && (flat || fw[(i + 2) % 3] <= 0)) begin
        for (k = 0; k < 3; k++) begin
          num = ew[i][0] * p[i][k] + ew[i][1] * p[j][k];
          c[k] = wide_t'($signed(div_nearest(num, ew[i][2])));
        end
        r.px = c[0]; r.py = c[1]; r.pz = c[2];
        r.reg_code = (i == 0) ? REG_AB : (i == 1) ? REG_BC : REG_CA;
        return r;
      end
    end
    if (flat) begin
      r.reg_code = REG_DEGEN;
      r.ok = 1'b0;
      return r;
    end
    for (k = 0; k < 3; k++) begin
      num = fw[0] * p[0][k] + fw[1] * p[1][k] + fw[2] * p[2][k];
      c[k] = wide_t'($signed(div_nearest(num, fs)));
    end
    r.px = c[0]; r.py = c[1]; r.pz = c[2];
    r.reg_code = REG_FACE;
    return r;
  endfunction

  // Busy and the result ports are stable at the falling edge.
  always @(negedge clk) begin
    answer_t want;
    busy_seen <= busy;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        region_hits[want.reg_code]++;
        if (near_x !== want.px) begin
          $error("near_x: expected %0d, got %0d", want.px, near_x);
          fail_count++;
        end
        if (near_y !== want.py) begin
          $error("near_y: expected %0d, got %0d", want.py, near_y);
          fail_count++;
        end
        if (near_z !== want.pz) begin
          $error("near_z: expected %0d, got %0d", want.pz, near_z);
          fail_count++;
        end
        if (region !== want.reg_code) begin
          $error("region: expected %0d, got %0d", want.reg_code, region);
          fail_count++;
        end
        if (valid_res !== want.ok) begin
          $error("valid_res: expected %0d, got %0d", want.ok, valid_res);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_request(query_t t);
    start <= 1'b1;
    {ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy, qz} <= t;
    do @(posedge clk); while (busy_seen);
    pending_answers = {pending_answers, closest_point(t)};
    request_count++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] fx(int v);
    return v <<< 16;
  endfunction

  function automatic query_t make_query(logic signed [CW-1:0] a0, a1, a2, b0, b1, b2,
                                        c0, c1, c2, q0, q1, q2);
    query_t t;
    t = {a0, a1, a2, b0, b1, b2, c0, c1, c2, q0, q1, q2};
    return t;
  endfunction

  task automatic test_regions();
    logic signed [CW-1:0] one;
    logic signed [CW-1:0] mx;
    logic signed [CW-1:0] mn;
    one = fx(1);
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    // Right triangle in the xy plane, queries in each Voronoi region.
    send_request(make_query(0, 0, 0, one, 0, 0, 0, one, 0, -one, -one, one));
    send_request(make_query(0, 0, 0, one, 0, 0, 0, one, 0, fx(3), -one, 0));
    send_request(make_query(0, 0, 0, one, 0, 0, 0, one, 0, -one, fx(3), -one));
    send_request(make_query(0, 0, 0, one, 0, 0, 0, one, 0, one / 3, -one, fx(2)));
    send_request(make_query(0, 0, 0, one, 0, 0, 0, one, 0, one, one, 5));
    send_request(make_query(0, 0, 0, one, 0, 0, 0, one, 0, -one, one / 7, 3));
    send_request(make_query(0, 0, 0, one, 0, 0, 0, one, 0, one / 5, one / 3, fx(7)));
    pause(3);
    // Collinear and coincident triangles.
    send_request(make_query(0, 0, 0, fx(2), 0, 0, one, 0, 0, one, one, 0));
    send_request(make_query(0, 0, 0, 0, 0, 0, fx(2), 0, 0, one, one, one));
    send_request(make_query(5, 5, 5, 5, 5, 5, 5, 5, 5, -9, 3, 1));
    send_request(make_query(0, 0, 0, fx(4), 0, 0, fx(2), 0, 0, fx(9), fx(1), 0));
    send_request(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Extremes of the coordinate range.
    send_request(make_query(mn, mn, mn, mx, mn, mn, mn, mx, mn, mx, mx, mx));
    send_request(make_query(mn, mn, mn, mx, mn, mn, mn, mx, mn, 0, 0, mx));
    send_request(make_query(mx, mx, mx, mn, mx, mx, mx, mn, mx, mn, mn, mn));
    send_request(make_query(mx, mn, 0, mn, mx, 0, 0, 0, mx, 0, 0, mn));
    send_request(make_query(mn, 0, mx, mx, 0, mn, 0, mx, 0, mx, mn, mx));
    send_request(make_query(-1, -1, -1, 1, -1, 1, -1, 1, 1, 0, 0, 0));
    send_request(make_query(mx, mx, mx, mx, mx, mx, mn, mn, mn, 0, 0, 0));
    pause(2);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int span_bits);
    logic signed [CW-1:0] v;
    v = $urandom;
    if (span_bits < CW) v = v >>> (CW - span_bits);
    return v;
  endfunction

  task automatic test_random(int count);
    query_t t;
    logic signed [CW-1:0] v[12];
    int span;
    int kind;
    int burst;
    int i;
    int k;
    burst = $urandom_range(1, 20);
    for (i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      span = (kind == 0) ? CW : $urandom_range(4, 24);
      for (k = 0; k < 12; k++) v[k] = rand_coord(span);
      if (kind == 1) begin
        // C on the line through A and B.
        for (k = 0; k < 3; k++)
          v[6 + k] = v[k] + (v[3 + k] - v[k]) * $signed($urandom_range(0, 6) - 3);
      end else if (kind == 2) begin
        for (k = 0; k < 3; k++) v[3 + k] = v[k];
      end else if (kind >= 3 && kind <= 6) begin
        // Query close to the triangle so the edge and face regions are hit often.
        for (k = 0; k < 3; k++)
          v[9 + k] = (v[k] >>> 2) + (v[3 + k] >>> 2) + (v[6 + k] >>> 2) + (v[9 + k] >>> 3);
      end
      t = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
      send_request(t);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    int n;
    rst = 1'b1;
    start = 1'b0;
    {ax, ay, az, bx, by, bz, cx, cy, cz, qx, qy, qz} = '0;
    busy_seen = 1'b1;
    fail_count = 0;
    cycle_count = 0;
    request_count = 0;
    for (n = 0; n < 8; n++) region_hits[n] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_regions();
    test_random(1650);
    n = 0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests; vertex %0d/%0d/%0d, edge %0d/%0d/%0d,",
             request_count, region_hits[0], region_hits[1], region_hits[2],
             region_hits[3], region_hits[4], region_hits[5]);
    $display("face %0d, degenerate %0d results checked.", region_hits[6], region_hits[7]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
